// ===== src/i2cs_pkg.sv =====
package i2cs_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_EVENT = 2'd1;
    localparam logic [1:0] ACT_ABORT = 2'd2;

    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_ERROR   = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_ABORTED = 3'd4;

    localparam logic [2:0] PH_WR_ADDR = 3'd0;
    localparam logic [2:0] PH_COMMAND = 3'd1;
    localparam logic [2:0] PH_WR_DATA = 3'd2;
    localparam logic [2:0] PH_RD_ADDR = 3'd3;
    localparam logic [2:0] PH_RD_DATA = 3'd4;

    localparam logic [7:0] CTRL_START    = 8'h85;
    localparam logic [7:0] CTRL_RESTART  = 8'hC5;
    localparam logic [7:0] CTRL_CONTINUE = 8'h84;
    localparam logic [7:0] CTRL_ACK_READ = 8'hA4;
    localparam logic [7:0] CTRL_STOP     = 8'h00;

    localparam int ECTL_MASTER_BIT = 7;
    localparam int EST_NACK_BIT    = 6;
    localparam int EST_ERROR_BIT   = 5;

    localparam logic [2:0] REG_SLAVE_ADDRESS = 3'd0;
    localparam logic [2:0] REG_RETRY_LIMIT   = 3'd1;
    localparam logic [2:0] REG_COMMAND_COUNT = 3'd2;
    localparam logic [2:0] REG_COMMAND_BYTES = 3'd3;
    localparam logic [2:0] REG_DATA_COUNT    = 3'd4;
    localparam logic [2:0] REG_READ_MODE     = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CMD_BYTES  = 4;

    typedef struct packed {
        logic [6:0]  slave_address;
        logic [7:0]  retry_limit;
        logic [2:0]  command_count;
        logic [31:0] command_bytes;
        logic [15:0] data_count;
        logic        read_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] engine_control;
        logic [7:0] engine_status;
        logic [7:0] rx_byte;
        logic [7:0] write_byte;
    } item_t;

    typedef struct packed {
        logic       start_accepted;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       ctrl_valid;
        logic [7:0] ctrl_value;
        logic       write_taken;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       done_res;
        logic [2:0] result_status;
    } result_t;

endpackage

// ===== src/i2c_master_transaction_sequencer.sv =====
// Sequences one I2C master transaction (write address, one to MAX_COMMANDS command
// bytes, then N data bytes written or a repeated start and N bytes read, the last
// one NACKed) on top of a byte-level bus engine. Each input word is a start, a bus
// event or an abort and gives exactly one result word carrying the transmit byte,
// the engine control write, received data and the status. A word is taken into an
// input register, decided combinationally against the transaction state and placed in
// an output register, so one word is accepted per clock as long as results are
// taken; a stalled result holds the pipeline after one more word is buffered.
// Configuration writes are meant for idle periods and take effect at once.
module i2c_master_transaction_sequencer #(
    parameter int MAX_COMMANDS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [i2cs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [i2cs_pkg::CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [7:0]                      s_engine_control,
    input  logic [7:0]                      s_engine_status,
    input  logic [7:0]                      s_rx_byte,
    input  logic [7:0]                      s_write_byte,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_start_accepted,
    output logic                            m_tx_valid,
    output logic [7:0]                      m_tx_byte,
    output logic                            m_ctrl_valid,
    output logic [7:0]                      m_ctrl_value,
    output logic                            m_write_taken,
    output logic                            m_rx_valid,
    output logic [7:0]                      m_rx_data,
    output logic                            m_done_res,
    output logic [2:0]                      m_result_status
);

    i2cs_pkg::cfg_t    cfg;
    i2cs_pkg::item_t   in_item_reg;
    i2cs_pkg::result_t step_res;
    i2cs_pkg::result_t out_res_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    i2cs_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    i2cs_core #(
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.action         <= s_action;
            in_item_reg.engine_control <= s_engine_control;
            in_item_reg.engine_status  <= s_engine_status;
            in_item_reg.rx_byte        <= s_rx_byte;
            in_item_reg.write_byte     <= s_write_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_start_accepted = out_res_reg.start_accepted;
    assign m_tx_valid       = out_res_reg.tx_valid;
    assign m_tx_byte        = out_res_reg.tx_byte;
    assign m_ctrl_valid     = out_res_reg.ctrl_valid;
    assign m_ctrl_value     = out_res_reg.ctrl_value;
    assign m_write_taken    = out_res_reg.write_taken;
    assign m_rx_valid       = out_res_reg.rx_valid;
    assign m_rx_data        = out_res_reg.rx_data;
    assign m_done_res       = out_res_reg.done_res;
    assign m_result_status  = out_res_reg.result_status;

endmodule

// ===== src/i2cs_cfg.sv =====
module i2cs_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [i2cs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [i2cs_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output i2cs_pkg::cfg_t                    cfg
);

    i2cs_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_address <= '0;
            cfg_reg.retry_limit   <= '0;
            cfg_reg.command_count <= 3'd1;
            cfg_reg.command_bytes <= '0;
            cfg_reg.data_count    <= '0;
            cfg_reg.read_mode     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                i2cs_pkg::REG_SLAVE_ADDRESS: cfg_reg.slave_address <= cfg_wr_data[6:0];
                i2cs_pkg::REG_RETRY_LIMIT:   cfg_reg.retry_limit   <= cfg_wr_data[7:0];
                i2cs_pkg::REG_COMMAND_COUNT: cfg_reg.command_count <= cfg_wr_data[2:0];
                i2cs_pkg::REG_COMMAND_BYTES: cfg_reg.command_bytes <= cfg_wr_data[31:0];
                i2cs_pkg::REG_DATA_COUNT:    cfg_reg.data_count    <= cfg_wr_data[15:0];
                i2cs_pkg::REG_READ_MODE:     cfg_reg.read_mode     <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/i2cs_core.sv =====
module i2cs_core #(
    parameter int MAX_COMMANDS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  i2cs_pkg::cfg_t    cfg,
    input  i2cs_pkg::item_t   item,
    output i2cs_pkg::result_t res
);

    localparam int CW = $clog2(MAX_COMMANDS + 1);

    logic          busy_reg, busy_next;
    logic [2:0]    phase_reg, phase_next;
    logic [7:0]    retries_reg, retries_next;
    logic [CW-1:0] cmds_left_reg, cmds_left_next;
    logic [CW-1:0] cmd_idx_reg, cmd_idx_next;
    logic [15:0]   data_left_reg, data_left_next;
    logic [2:0]    status_reg, status_next;

    logic [CW-1:0] n_cmds;
    logic [7:0]    cmd_byte;
    logic [15:0]   rd_left;
    logic [2:0]    eot;
    logic          nack;

    always_comb begin
        if (cfg.command_count == 3'd0) begin
            n_cmds = CW'(1);
        end else if (int'(cfg.command_count) > MAX_COMMANDS) begin
            n_cmds = CW'(MAX_COMMANDS);
        end else begin
            n_cmds = CW'(cfg.command_count);
        end
    end

    // command bytes past the fourth read as zero
    always_comb begin
        cmd_byte = 8'h00;
        for (int k = 0; k < i2cs_pkg::CMD_BYTES; k++) begin
            if (int'(cmd_idx_reg) == k) begin
                cmd_byte = cfg.command_bytes[8*k +: 8];
            end
        end
    end

    assign nack    = item.engine_status[i2cs_pkg::EST_NACK_BIT];
    assign rd_left = data_left_reg - 16'd1;

    always_comb begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        retries_next   = retries_reg;
        cmds_left_next = cmds_left_reg;
        cmd_idx_next   = cmd_idx_reg;
        data_left_next = data_left_reg;
        status_next    = status_reg;
        eot            = i2cs_pkg::ST_BUSY;
        res            = '0;

        case (item.action)
            i2cs_pkg::ACT_START: begin
                if (!busy_reg) begin
                    busy_next          = 1'b1;
                    status_next        = i2cs_pkg::ST_BUSY;
                    retries_next       = cfg.retry_limit;
                    cmds_left_next     = n_cmds;
                    cmd_idx_next       = '0;
                    data_left_next     = cfg.data_count;
                    phase_next         = i2cs_pkg::PH_WR_ADDR;
                    res.start_accepted = 1'b1;
                    res.tx_valid       = 1'b1;
                    res.tx_byte        = {cfg.slave_address, 1'b0};
                    res.ctrl_valid     = 1'b1;
                    res.ctrl_value     = i2cs_pkg::CTRL_START;
                end
            end
            i2cs_pkg::ACT_EVENT: begin
                if (!busy_reg) begin
                    res.ctrl_valid = 1'b1;
                    res.ctrl_value = i2cs_pkg::CTRL_STOP;
                end else if (!item.engine_control[i2cs_pkg::ECTL_MASTER_BIT] ||
                             item.engine_status[i2cs_pkg::EST_ERROR_BIT]) begin
                    eot = i2cs_pkg::ST_ERROR;
                end else begin
                    case (phase_reg)
                        i2cs_pkg::PH_WR_ADDR: begin
                            if (nack) begin
                                if (retries_reg != 8'd0) begin
                                    retries_next   = retries_reg - 8'd1;
                                    res.tx_valid   = 1'b1;
                                    res.tx_byte    = {cfg.slave_address, 1'b0};
                                    res.ctrl_valid = 1'b1;
                                    res.ctrl_value = i2cs_pkg::CTRL_RESTART;
                                end else begin
                                    eot = i2cs_pkg::ST_TIMEOUT;
                                end
                            end else begin
                                cmds_left_next = cmds_left_reg - CW'(1);
                                cmd_idx_next   = CW'(1);
                                phase_next     = i2cs_pkg::PH_COMMAND;
                                res.tx_valid   = 1'b1;
                                res.tx_byte    = cfg.command_bytes[7:0];
                                res.ctrl_valid = 1'b1;
                                res.ctrl_value = i2cs_pkg::CTRL_CONTINUE;
                            end
                        end
                        i2cs_pkg::PH_COMMAND: begin
                            if (nack) begin
                                eot = i2cs_pkg::ST_ABORTED;
                            end else if (cmds_left_reg != '0) begin
                                cmds_left_next = cmds_left_reg - CW'(1);
                                cmd_idx_next   = cmd_idx_reg + CW'(1);
                                res.tx_valid   = 1'b1;
                                res.tx_byte    = cmd_byte;
                                res.ctrl_valid = 1'b1;
                                res.ctrl_value = i2cs_pkg::CTRL_CONTINUE;
                            end else if (data_left_reg != 16'd0) begin
                                res.tx_valid   = 1'b1;
                                res.ctrl_valid = 1'b1;
                                if (!cfg.read_mode) begin
                                    data_left_next  = rd_left;
                                    phase_next      = i2cs_pkg::PH_WR_DATA;
                                    res.tx_byte     = item.write_byte;
                                    res.write_taken = 1'b1;
                                    res.ctrl_value  = i2cs_pkg::CTRL_CONTINUE;
                                end else begin
                                    phase_next     = i2cs_pkg::PH_RD_ADDR;
                                    res.tx_byte    = {cfg.slave_address, 1'b1};
                                    res.ctrl_value = i2cs_pkg::CTRL_RESTART;
                                end
                            end else begin
                                eot = i2cs_pkg::ST_OK;
                            end
                        end
                        i2cs_pkg::PH_WR_DATA: begin
                            if (nack) begin
                                eot = i2cs_pkg::ST_ABORTED;
                            end else if (data_left_reg != 16'd0) begin
                                data_left_next  = rd_left;
                                res.tx_valid    = 1'b1;
                                res.tx_byte     = item.write_byte;
                                res.write_taken = 1'b1;
                                res.ctrl_valid  = 1'b1;
                                res.ctrl_value  = i2cs_pkg::CTRL_CONTINUE;
                            end else begin
                                eot = i2cs_pkg::ST_OK;
                            end
                        end
                        i2cs_pkg::PH_RD_ADDR: begin
                            if (nack) begin
                                eot = i2cs_pkg::ST_ABORTED;
                            end else begin
                                phase_next     = i2cs_pkg::PH_RD_DATA;
                                res.ctrl_valid = 1'b1;
                                res.ctrl_value = (data_left_reg > 16'd1) ?
                                                 i2cs_pkg::CTRL_ACK_READ :
                                                 i2cs_pkg::CTRL_CONTINUE;
                            end
                        end
                        i2cs_pkg::PH_RD_DATA: begin
                            res.rx_valid = 1'b1;
                            res.rx_data  = item.rx_byte;
                            if (rd_left != 16'd0) begin
                                data_left_next = rd_left;
                                res.ctrl_valid = 1'b1;
                                res.ctrl_value = (rd_left > 16'd1) ?
                                                 i2cs_pkg::CTRL_ACK_READ :
                                                 i2cs_pkg::CTRL_CONTINUE;
                            end else begin
                                eot = i2cs_pkg::ST_OK;
                            end
                        end
                        default: begin
                            eot = i2cs_pkg::ST_ERROR;
                        end
                    endcase
                end
                if (eot != i2cs_pkg::ST_BUSY) begin
                    res.ctrl_valid = 1'b1;
                    res.ctrl_value = i2cs_pkg::CTRL_STOP;
                    res.done_res   = 1'b1;
                    busy_next      = 1'b0;
                    status_next    = eot;
                end
            end
            i2cs_pkg::ACT_ABORT: begin
                res.ctrl_valid = 1'b1;
                res.ctrl_value = i2cs_pkg::CTRL_STOP;
                busy_next      = 1'b0;
            end
            default: begin
            end
        endcase

        res.result_status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= i2cs_pkg::PH_WR_ADDR;
            retries_reg   <= '0;
            cmds_left_reg <= '0;
            cmd_idx_reg   <= '0;
            data_left_reg <= '0;
            status_reg    <= i2cs_pkg::ST_BUSY;
        end else if (fire) begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            retries_reg   <= retries_next;
            cmds_left_reg <= cmds_left_next;
            cmd_idx_reg   <= cmd_idx_next;
            data_left_reg <= data_left_next;
            status_reg    <= status_next;
        end
    end

endmodule

// ===== src/i2cs_checker.sv =====
module i2cs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_start_accepted,
    input logic       m_tx_valid,
    input logic [7:0] m_tx_byte,
    input logic       m_ctrl_valid,
    input logic [7:0] m_ctrl_value,
    input logic       m_write_taken,
    input logic       m_rx_valid,
    input logic [7:0] m_rx_data,
    input logic       m_done_res,
    input logic [2:0] m_result_status
);

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_ctrl_value) &&
            $stable(m_rx_data) && $stable(m_result_status) && $stable(m_done_res))
        else $error("stalled result word changed");

    // end of transaction stops the engine and leaves a final status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_ctrl_valid && m_ctrl_value == i2cs_pkg::CTRL_STOP &&
            m_result_status != i2cs_pkg::ST_BUSY && !m_start_accepted)
        else $error("done without stop or final status");

    // accepted start sends write address with start control
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_start_accepted |-> m_tx_valid && !m_tx_byte[0] && m_ctrl_valid &&
            m_ctrl_value == i2cs_pkg::CTRL_START && m_result_status == i2cs_pkg::ST_BUSY)
        else $error("bad start word");

    // write data word sends its byte with continue control, never with read data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_taken |-> m_tx_valid && !m_rx_valid &&
            m_ctrl_value == i2cs_pkg::CTRL_CONTINUE)
        else $error("bad write data word");

endmodule

bind i2c_master_transaction_sequencer i2cs_checker u_i2cs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_start_accepted (m_start_accepted),
    .m_tx_valid       (m_tx_valid),
    .m_tx_byte        (m_tx_byte),
    .m_ctrl_valid     (m_ctrl_valid),
    .m_ctrl_value     (m_ctrl_value),
    .m_write_taken    (m_write_taken),
    .m_rx_valid       (m_rx_valid),
    .m_rx_data        (m_rx_data),
    .m_done_res       (m_done_res),
    .m_result_status  (m_result_status)
);
